// ----- src/dwc_pkg.sv -----
// ----------------------------------------------------------------------------
// dwc_pkg
// shared types and codes for the double-ended queue with key search
// ----------------------------------------------------------------------------
`default_nettype none

package dwc_pkg;

   localparam int WORD_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_COUNT      = 3'd4;
   localparam logic [FUNC_W-1:0] OP_SEARCH     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   // broadcast shift control for the row of cells
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } shift_ctl_type;

endpackage

`default_nettype wire

// ----- src/deque_with_search.sv -----
// ----------------------------------------------------------------------------
// deque_with_search
// bounded double-ended queue of 32-bit words held in a row of cells, front
// entry in cell 0; search rotates the whole row once past cell 0
//
//   channel  ports                              handshake
//   request  req_func, req_value                start high and busy low
//   response rsp_status, rsp_found, rsp_count   rsp_valid, one cycle, no stall
//
// push, pop and count: result beat on the following cycle
// search: one cell compared per cycle as the row rotates
// busy is high during the rotation; start is ignored while busy
// reset is synchronous and clears the entry count; cell contents are kept
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_search #(
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [dwc_pkg::FUNC_W-1:0]            req_func,
   input  wire logic signed [dwc_pkg::WORD_W-1:0]     req_value,
   output logic                                       rsp_valid,
   output logic [dwc_pkg::STATUS_W-1:0]               rsp_status,
   output logic                                       rsp_found,
   output logic [dwc_pkg::COUNT_W-1:0]                rsp_count
);
   import dwc_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [0:0] {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        step_ff, step_in;
   logic                    found_ff, found_in;
   word_type                key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   shift_ctl_type           ctl;
   logic [DEPTH-1:0]        load;
   word_type                cell_q [DEPTH];
   word_type                value_bits;
   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   logic                    scan_last;
   logic                    hit;
   logic [COUNT_W+CNT_W-1:0] cnt_wide;

   assign value_bits = word_type'($unsigned(req_value));
   assign accept     = start && (state_ff == S_IDLE);
   assign is_full    = (cnt_ff == CNT_W'(DEPTH));
   assign is_empty   = (cnt_ff == '0);
   assign scan_last  = (state_ff == S_SCAN) && (step_ff == IDX_W'(DEPTH - 1));
   assign hit        = (CNT_W'(step_ff) < cnt_ff) && (cell_q[0] == key_ff);

   // row of cells, ring-connected for rotation
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      dwc_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load     (load[i]),
         .value_in (value_bits),
         .left_in  ((i == 0) ? value_bits : cell_q[(i + DEPTH - 1) % DEPTH]),
         .right_in (cell_q[(i + 1) % DEPTH]),
         .q        (cell_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      ctl           = '0;
      load          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_found_in  = 1'b0;
               unique case (req_func)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.shift_up = 1'b1;
                        cnt_in       = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           load[i] = (cnt_ff[IDX_W-1:0] == IDX_W'(i));
                        end
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ctl.shift_down = 1'b1;
                        cnt_in         = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        cnt_in = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_SEARCH: begin
                     rsp_valid_in = 1'b0;
                     key_in       = value_bits;
                     found_in     = 1'b0;
                     step_in      = '0;
                     state_in     = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            ctl.shift_down = 1'b1;
            found_in       = found_ff | hit;
            step_in        = step_ff + IDX_W'(1);
            if (scan_last) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_found_in  = found_ff | hit;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_wide     = {{COUNT_W{1'b0}}, cnt_in};
   assign rsp_count_in = cnt_wide[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      found_ff      <= found_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy       = (state_ff == S_SCAN);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_beat_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept) || $past(scan_last))
      else $error("response beat without a request or scan end");

   a_scan_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> $stable(cnt_ff))
      else $error("entry count changed during search");

   a_full_only_at_depth: assert property (@(posedge clock) disable iff (reset)
      accept && is_full && (req_func == OP_PUSH_BACK || req_func == OP_PUSH_FRONT)
      |=> rsp_valid_ff && (rsp_status_ff == ST_FULL))
      else $error("push into full queue not flagged");

endmodule

`default_nettype wire

// ----- src/dwc_cell.sv -----
// ----------------------------------------------------------------------------
// dwc_cell
// one word of the queue row; loads, takes a neighbour's word or holds
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_cell (
   input  wire logic                  clock,
   input  wire dwc_pkg::shift_ctl_type ctl,
   input  wire logic                  load,
   input  wire dwc_pkg::word_type     value_in,
   input  wire dwc_pkg::word_type     left_in,
   input  wire dwc_pkg::word_type     right_in,
   output dwc_pkg::word_type          q
);
   import dwc_pkg::*;

   word_type data_ff;
   word_type data_in;

   always_comb begin
      priority if (load) begin
         data_in = value_in;
      end else if (ctl.shift_up) begin
         data_in = left_in;
      end else if (ctl.shift_down) begin
         data_in = right_in;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

`default_nettype wire
